// ===== src/qpht_pkg.sv =====
// Package for the quadratic probe hash table: sizes, codes and the word type
// passed from the front end to the probe engine. No dependencies.
package qpht_pkg;
	localparam int SLOTS = 1021;
	localparam int KEY_BITS = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	// The probe count must hold SLOTS itself.
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int FIFO_DEPTH = 2;
	// Scaled reciprocal for key_hash mod SLOTS: floor(2^(32+SLOT_W) / SLOTS) + 1.
	// The quotient (hash * MAGIC) >> MAGIC_SH is exact for every 32-bit hash
	// when SLOTS is not a power of two.
	localparam int MAGIC_SH = 32 + SLOT_W;
	localparam logic [32:0] MAGIC = 33'((64'd1 << MAGIC_SH) / 64'(SLOTS) + 64'd1);

	typedef enum logic [0:0] {
		FUNC_INSERT = 1'b0,
		FUNC_LOOKUP = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_FOUND = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		func_t func;
		logic [KEY_BITS-1:0] key;
		logic [SLOT_W-1:0] home;
		logic [31:0] value;
	} req_t;
endpackage

// ===== src/qpht_front.sv =====
// Front end: accepts command words, reduces the hash to the home slot with a
// reciprocal multiplication, and pushes the request into a short queue.
// Depends on qpht_pkg.
module qpht_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic func,
	input logic [63:0] key,
	input logic [31:0] key_hash,
	input logic signed [31:0] value,
	output logic req_valid,
	input logic req_take,
	output qpht_pkg::req_t req
);
	// Phase 0 registers the product; phase 1 forms rem and enqueues.
	logic busy_q;
	logic phase_q;
	logic [31:0] hash_q;
	logic [64:0] prod_q;
	qpht_pkg::req_t hold_q;
	logic [31:0] quot;
	logic [31:0] rem;
	qpht_pkg::req_t enq_word;
	qpht_pkg::req_t fifo_q [qpht_pkg::FIFO_DEPTH];
	logic [1:0] count_q;
	logic rd_q, wr_q;
	logic enq, deq;

	assign quot = 32'(prod_q >> qpht_pkg::MAGIC_SH);
	assign rem = hash_q - quot * 32'(qpht_pkg::SLOTS);
	assign full = busy_q;
	assign enq = busy_q && phase_q && count_q != 2'(qpht_pkg::FIFO_DEPTH);
	assign deq = req_take && req_valid;
	assign req_valid = count_q != 2'd0;
	assign req = fifo_q[rd_q];

	always_comb begin
		enq_word = hold_q;
		enq_word.home = rem[qpht_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			count_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push && !busy_q) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (enq) begin
				busy_q <= 1'b0;
			end
			if (enq) wr_q <= !wr_q;
			if (deq) rd_q <= !rd_q;
			count_q <= count_q + {1'b0, enq} - {1'b0, deq};
		end
	end

	always_ff @(posedge clk) begin
		if (push && !busy_q) begin
			hash_q <= key_hash;
			hold_q.func <= qpht_pkg::func_t'(func);
			hold_q.key <= key[qpht_pkg::KEY_BITS-1:0];
			hold_q.home <= '0;
			hold_q.value <= value;
		end
		if (busy_q && !phase_q) prod_q <= {33'b0, hash_q} * {32'b0, qpht_pkg::MAGIC};
		if (enq) fifo_q[wr_q] <= enq_word;
	end
endmodule

// ===== src/qpht_back.sv =====
// Back end: probe engine over the slot memories and result queue.
// Depends on qpht_pkg.
module qpht_back (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_take,
	input qpht_pkg::req_t req,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic signed [31:0] found_value
);
	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_DONE} state_t;
	state_t state_q;
	logic [qpht_pkg::SLOT_W-1:0] pos_q, clr_q;
	logic [qpht_pkg::SLOT_W:0] step_q;
	logic [qpht_pkg::CNT_W-1:0] cnt_q;
	qpht_pkg::req_t cur_q;
	logic used_mem [qpht_pkg::SLOTS];
	logic [qpht_pkg::KEY_BITS-1:0] key_mem [qpht_pkg::SLOTS];
	logic [31:0] val_mem [qpht_pkg::SLOTS];
	logic used_rd_q;
	logic [qpht_pkg::KEY_BITS-1:0] key_rd_q;
	logic [31:0] val_rd_q;
	logic used_we, kv_we;
	logic used_wd;
	logic [qpht_pkg::SLOT_W-1:0] used_wa;
	logic [qpht_pkg::SLOT_W+1:0] pos_sum, step_sum;
	logic [qpht_pkg::SLOT_W-1:0] pos_next;
	logic [qpht_pkg::SLOT_W:0] step_next;
	logic [1:0] res_status_q;
	logic [31:0] res_fval_q;
	logic [1:0] status_q;
	logic [31:0] fval_q;
	logic out_valid_q;
	logic load_out;

	// (c+1)^2 - c^2 = 2c + 1, both kept reduced mod SLOTS.
	assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_next = (pos_sum >= (qpht_pkg::SLOT_W+2)'(qpht_pkg::SLOTS))
		? qpht_pkg::SLOT_W'(pos_sum - (qpht_pkg::SLOT_W+2)'(qpht_pkg::SLOTS))
		: pos_sum[qpht_pkg::SLOT_W-1:0];
	assign step_sum = {1'b0, step_q} + (qpht_pkg::SLOT_W+2)'(2);
	assign step_next = (step_sum >= (qpht_pkg::SLOT_W+2)'(qpht_pkg::SLOTS))
		? (qpht_pkg::SLOT_W+1)'(step_sum - (qpht_pkg::SLOT_W+2)'(qpht_pkg::SLOTS))
		: step_sum[qpht_pkg::SLOT_W:0];

	assign req_take = state_q == S_IDLE && req_valid;
	assign empty = !out_valid_q;
	assign status = status_q;
	assign found_value = fval_q;
	// The finished result moves to the output register once that is free or
	// its word is being taken.
	assign load_out = state_q == S_DONE && (!out_valid_q || pop);

	always_comb begin
		used_we = 1'b0;
		used_wd = 1'b0;
		used_wa = clr_q;
		kv_we = 1'b0;
		if (state_q == S_CLEAR) begin
			used_we = 1'b1;
		end else if (state_q == S_CHECK && cur_q.func == qpht_pkg::FUNC_INSERT
				&& !used_rd_q) begin
			used_we = 1'b1;
			used_wd = 1'b1;
			used_wa = pos_q;
			kv_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) used_mem[used_wa] <= used_wd;
		if (kv_we) begin
			key_mem[pos_q] <= cur_q.key;
			val_mem[pos_q] <= cur_q.value;
		end
		used_rd_q <= used_mem[pos_q];
		key_rd_q <= key_mem[pos_q];
		val_rd_q <= val_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == qpht_pkg::SLOT_W'(qpht_pkg::SLOTS - 1)) state_q <= S_IDLE;
					else clr_q <= clr_q + 1'b1;
				end
				S_IDLE: begin
					if (req_valid) begin
						cur_q <= req;
						pos_q <= req.home;
						step_q <= (qpht_pkg::SLOT_W+1)'(1);
						cnt_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (!used_rd_q) begin
						res_status_q <= (cur_q.func == qpht_pkg::FUNC_INSERT)
							? qpht_pkg::ST_STORED : qpht_pkg::ST_NOT_FOUND;
						res_fval_q <= '0;
						state_q <= S_DONE;
					end else if (cur_q.func == qpht_pkg::FUNC_LOOKUP
							&& key_rd_q == cur_q.key) begin
						res_status_q <= qpht_pkg::ST_FOUND;
						res_fval_q <= val_rd_q;
						state_q <= S_DONE;
					end else if (cnt_q == qpht_pkg::CNT_W'(qpht_pkg::SLOTS - 1)) begin
						res_status_q <= (cur_q.func == qpht_pkg::FUNC_INSERT)
							? qpht_pkg::ST_FULL : qpht_pkg::ST_NOT_FOUND;
						res_fval_q <= '0;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						pos_q <= pos_next;
						step_q <= step_next;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (load_out) begin
						status_q <= res_status_q;
						fval_q <= res_fval_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/quadratic_probe_hash_table.sv =====
// Top level of the quadratic probe hash table; joins front end and probe
// engine. Depends on qpht_pkg, qpht_front and qpht_back.
//
// The block is a closed hash table of qpht_pkg::SLOTS slots. Each command word
// inserts a key and value or looks a key up; every word yields exactly one
// result word (status and found_value) in order. The front end keeps full high
// after each accepted word while it multiplies key_hash by a scaled reciprocal
// of SLOTS, forms the home slot and queues the request; it takes no new word
// until that request is queued. The probe engine takes a request, reads the
// slot memories through one registered read port for each probe (S_READ, then
// S_CHECK) and then loads the result register. In steady state the hash
// reduction of one word overlaps the previous word's probing. A result that
// waits for pop holds the engine once the next word has been probed. After
// reset the occupancy memory is cleared one slot at a time; commands queue
// meanwhile and results start after.
module quadratic_probe_hash_table (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic func,
	input logic [63:0] key,
	input logic [31:0] key_hash,
	input logic signed [31:0] value,
	output logic empty,
	input logic pop,
	output logic [1:0] status,
	output logic signed [31:0] found_value
);
	// Request path between front end and probe engine.
	logic req_valid;
	logic req_take;
	qpht_pkg::req_t req;

	qpht_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.key(key), .key_hash(key_hash), .value(value),
		.req_valid(req_valid), .req_take(req_take), .req(req)
	);

	qpht_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_take(req_take),
		.req(req), .empty(empty), .pop(pop), .status(status),
		.found_value(found_value)
	);
endmodule

// ===== src/qpht_checker.sv =====
// Port checker for the hash table, bound to the top level.
// Depends on qpht_pkg and quadratic_probe_hash_table's ports.
module qpht_props (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input logic [1:0] status,
	input logic signed [31:0] found_value
);
	// A waiting result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(found_value))
		else $error("result changed while waiting");
	// Only a found status carries a value.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != qpht_pkg::ST_FOUND |-> found_value == 32'sd0)
		else $error("nonzero value without found");
	// An accepted word occupies the front end in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("front end not busy after accept");
endmodule

bind quadratic_probe_hash_table qpht_props u_qpht_props (.*);
